// ===== hdl/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Leak state classifier package
// Shared widths, register indexes, status codes, scoring constants and the
// stage-two control structure of the leak state classifier.
// ----------------------------------------------------------------------------
package lsc_pkg;

    // Field widths.
    localparam int DATA_W  = 16;
    localparam int RISK_W  = 7;
    localparam int CNT_W   = 4;
    localparam int CFG_IDX_W = 4;

    // Default values of the module parameters.
    localparam int NO_FLOW_MAX_DEF       = 5;
    localparam int CRITICAL_READINGS_DEF = 3;
    localparam int ALERT_READINGS_DEF    = 2;
    localparam int COUNT_CAP_DEF         = 10;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t REG_DEMO_MODE       = 4'd0;
    localparam cfg_index_t REG_FLOW_ALERT      = 4'd1;
    localparam cfg_index_t REG_FLOW_CRITICAL   = 4'd2;
    localparam cfg_index_t REG_PRS_ALERT       = 4'd3;
    localparam cfg_index_t REG_PRS_CRITICAL    = 4'd4;
    localparam cfg_index_t REG_PRS_RECOVERY    = 4'd5;
    localparam cfg_index_t REG_FLOW_EXIT       = 4'd6;
    localparam cfg_index_t REG_PRS_EXIT        = 4'd7;

    // Reset values of the threshold registers.
    localparam logic [DATA_W-1:0] FLOW_ALERT_RST    = 16'd200;
    localparam logic [DATA_W-1:0] FLOW_CRITICAL_RST = 16'd280;
    localparam logic [DATA_W-1:0] PRS_ALERT_RST     = 16'd2200;
    localparam logic [DATA_W-1:0] PRS_CRITICAL_RST  = 16'd1700;
    localparam logic [DATA_W-1:0] PRS_RECOVERY_RST  = 16'd2800;
    localparam logic [DATA_W-1:0] FLOW_EXIT_RST     = 16'd80;
    localparam logic [DATA_W-1:0] PRS_EXIT_RST      = 16'd2600;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_ALERT  = 2'd1,
        ST_LEAK   = 2'd2,
        ST_ERROR  = 2'd3
    } status_t;

    // Clamped span widths and score numerator width.
    localparam int FSPAN_W = 9;
    localparam int PSPAN_W = 11;
    localparam int NUM_W   = 18;

    // Normal ranges: flow 60..280, pressure 3000 down to 1700.
    localparam logic [DATA_W-1:0]  NRM_FLOW_LO   = 16'd60;
    localparam logic [DATA_W-1:0]  NRM_FLOW_HI   = 16'd280;
    localparam logic [FSPAN_W-1:0] NRM_FLOW_SPAN = 9'd220;
    localparam logic [DATA_W-1:0]  NRM_PRS_LO    = 16'd1700;
    localparam logic [DATA_W-1:0]  NRM_PRS_HI    = 16'd3000;
    localparam logic [PSPAN_W-1:0] NRM_PRS_SPAN  = 11'd1300;

    // Demo ranges: flow 900..1400, pressure 350 down to 120.
    localparam logic [DATA_W-1:0]  DEMO_FLOW_LO   = 16'd900;
    localparam logic [DATA_W-1:0]  DEMO_FLOW_HI   = 16'd1400;
    localparam logic [FSPAN_W-1:0] DEMO_FLOW_SPAN = 9'd500;
    localparam logic [DATA_W-1:0]  DEMO_PRS_LO    = 16'd120;
    localparam logic [DATA_W-1:0]  DEMO_PRS_HI    = 16'd350;
    localparam logic [PSPAN_W-1:0] DEMO_PRS_SPAN  = 11'd230;

    // Score weights: 55/45 scaled so the score is numerator / divisor.
    // Normal: (65*fn + 9*pn) / 260. Demo: (253*fn + 450*pn) / 2300.
    localparam logic [NUM_W-1:0] NRM_FLOW_WT  = 18'd65;
    localparam logic [NUM_W-1:0] NRM_PRS_WT   = 18'd9;
    localparam logic [NUM_W-1:0] DEMO_FLOW_WT = 18'd253;
    localparam logic [NUM_W-1:0] DEMO_PRS_WT  = 18'd450;

    // Score of 35 expressed as numerator thresholds (35 * divisor).
    localparam logic [NUM_W-1:0] NRM_RISK_HI_NUM  = 18'd9100;
    localparam logic [NUM_W-1:0] DEMO_RISK_HI_NUM = 18'd80500;

    // Divisors reduced by 4 (65 and 575), done as multiply by ceil(2^24/d).
    // The numerator is first shifted right by two.
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = 34;
    localparam logic [RECIP_W-1:0] NRM_RECIP  = 18'd258112;
    localparam logic [RECIP_W-1:0] DEMO_RECIP = 18'd29178;

    // Risk caps and fixed values.
    localparam logic [RISK_W-1:0] RISK_ERROR    = 7'd5;
    localparam logic [RISK_W-1:0] RISK_CAP_LOW  = 7'd15;
    localparam logic [RISK_W-1:0] RISK_CAP_HLTH = 7'd20;
    localparam logic [RISK_W-1:0] RISK_MAX      = 7'd100;

    // Flow above which the line counts as pressurized.
    localparam logic [DATA_W-1:0] LATCH_FLOW_MIN = 16'd20;

    // Decisions made in stage one and carried to stage two.
    typedef struct packed {
        logic             demo;
        logic             sensor_ok;
        logic             no_flow;
        logic             f_anom;
        logic             f_crit;
        logic             p_low;
        logic             p_crit;
        logic             p_recov;
        logic             f_exit;
        logic             p_exit;
        logic             f_latch;
        logic             risk_hi;
        logic [NUM_W-1:0] num;
    } s2_t;

endpackage

// ===== hdl/leak_state_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// Leak state classifier unit
// Classifies flow and pressure readings as normal, alert, leak or sensor
// error with counter hysteresis, and gives a 0..100 risk score.
// ----------------------------------------------------------------------------
// The block takes one reading per clock cycle while the result channel is
// not stalled, and returns one result for each, in order. A reading goes
// through three register stages: the input register, a stage that holds
// the threshold decisions and the weighted score numerator, and the result
// register. The score division is one constant reciprocal multiplier in
// the second stage, and the alert and critical counters and the
// pressurized latch are updated as a reading moves into the result
// register, so consecutive readings see each other's history with no
// gaps. Configuration writes are taken in any cycle and must be made while
// no reading is in flight.
module leak_state_classifier_unit #(
    parameter int NO_FLOW_MAX       = lsc_pkg::NO_FLOW_MAX_DEF,
    parameter int CRITICAL_READINGS = lsc_pkg::CRITICAL_READINGS_DEF,
    parameter int ALERT_READINGS    = lsc_pkg::ALERT_READINGS_DEF,
    parameter int COUNT_CAP         = lsc_pkg::COUNT_CAP_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write channel.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  lsc_pkg::cfg_index_t         cfg_index,
    input  logic [lsc_pkg::DATA_W-1:0]  cfg_data,
    // Reading channel.
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lsc_pkg::DATA_W-1:0]  flow,
    input  logic [lsc_pkg::DATA_W-1:0]  pressure,
    input  logic                        sensor_ok,
    // Result channel.
    output logic                        out_valid,
    input  logic                        out_ready,
    output lsc_pkg::status_t            status,
    output logic [lsc_pkg::RISK_W-1:0]  risk
);
    import lsc_pkg::*;

    localparam logic [CNT_W-1:0]  CAP_C    = CNT_W'(COUNT_CAP);
    localparam logic [CNT_W-1:0]  CRIT_C   = CNT_W'(CRITICAL_READINGS);
    localparam logic [CNT_W-1:0]  ALERT_C  = CNT_W'(ALERT_READINGS);
    localparam logic [DATA_W-1:0] NOFLOW_C = DATA_W'(NO_FLOW_MAX);

    // Configuration registers.
    logic              demo_mode_reg;
    logic [DATA_W-1:0] flow_alert_reg;
    logic [DATA_W-1:0] flow_crit_reg;
    logic [DATA_W-1:0] prs_alert_reg;
    logic [DATA_W-1:0] prs_crit_reg;
    logic [DATA_W-1:0] prs_recov_reg;
    logic [DATA_W-1:0] flow_exit_reg;
    logic [DATA_W-1:0] prs_exit_reg;

    // Pipeline valids and payloads.
    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_flow_reg;
    logic [DATA_W-1:0] s1_prs_reg;
    logic              s1_ok_reg;
    logic              s2_valid_reg;
    s2_t               s2_reg;
    s2_t               s2_next;
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [RISK_W-1:0] risk_reg;
    logic [RISK_W-1:0] risk_next;

    // Classifier state.
    logic [CNT_W-1:0]  alert_cnt_reg;
    logic [CNT_W-1:0]  alert_cnt_next;
    logic [CNT_W-1:0]  crit_cnt_reg;
    logic [CNT_W-1:0]  crit_cnt_next;
    logic              press_reg;
    logic              press_next;

    // Stage enables.
    logic out_en;
    logic s2_en;
    logic s1_en;

    // Stage-one arithmetic.
    logic [FSPAN_W-1:0] fn_nrm;
    logic [FSPAN_W-1:0] fn_demo;
    logic [PSPAN_W-1:0] pn_nrm;
    logic [PSPAN_W-1:0] pn_demo;
    logic [NUM_W-1:0]   num_nrm;
    logic [NUM_W-1:0]   num_demo;

    // Stage-two arithmetic.
    logic [DATA_W-1:0]  quot_in;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [RISK_W-1:0]  score;
    logic [RISK_W-1:0]  score_cap_low;
    logic [RISK_W-1:0]  score_cap_hlth;
    logic               crit;
    logic               alert;
    logic               healthy;
    logic               press_eff;
    logic [CNT_W-1:0]   alert_inc;
    logic [CNT_W-1:0]   alert_dec;
    logic [CNT_W-1:0]   crit_inc;
    logic [CNT_W-1:0]   crit_dec;

    // Handshake: each stage moves when the stage after it can take it.
    assign out_en    = !out_valid_reg || out_ready;
    assign s2_en     = !s2_valid_reg || out_en;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign in_ready  = s1_en;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign risk      = risk_reg;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            demo_mode_reg  <= 1'b0;
            flow_alert_reg <= FLOW_ALERT_RST;
            flow_crit_reg  <= FLOW_CRITICAL_RST;
            prs_alert_reg  <= PRS_ALERT_RST;
            prs_crit_reg   <= PRS_CRITICAL_RST;
            prs_recov_reg  <= PRS_RECOVERY_RST;
            flow_exit_reg  <= FLOW_EXIT_RST;
            prs_exit_reg   <= PRS_EXIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEMO_MODE:     demo_mode_reg  <= cfg_data[0];
                REG_FLOW_ALERT:    flow_alert_reg <= cfg_data;
                REG_FLOW_CRITICAL: flow_crit_reg  <= cfg_data;
                REG_PRS_ALERT:     prs_alert_reg  <= cfg_data;
                REG_PRS_CRITICAL:  prs_crit_reg   <= cfg_data;
                REG_PRS_RECOVERY:  prs_recov_reg  <= cfg_data;
                REG_FLOW_EXIT:     flow_exit_reg  <= cfg_data;
                REG_PRS_EXIT:      prs_exit_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamped flow and pressure fractions for both ranges.
    always_comb
    begin
        if (s1_flow_reg <= NRM_FLOW_LO)
            fn_nrm = '0;
        else if (s1_flow_reg >= NRM_FLOW_HI)
            fn_nrm = NRM_FLOW_SPAN;
        else
            fn_nrm = FSPAN_W'(s1_flow_reg - NRM_FLOW_LO);

        if (s1_flow_reg <= DEMO_FLOW_LO)
            fn_demo = '0;
        else if (s1_flow_reg >= DEMO_FLOW_HI)
            fn_demo = DEMO_FLOW_SPAN;
        else
            fn_demo = FSPAN_W'(s1_flow_reg - DEMO_FLOW_LO);

        if (s1_prs_reg >= NRM_PRS_HI)
            pn_nrm = '0;
        else if (s1_prs_reg <= NRM_PRS_LO)
            pn_nrm = NRM_PRS_SPAN;
        else
            pn_nrm = PSPAN_W'(NRM_PRS_HI - s1_prs_reg);

        if (s1_prs_reg >= DEMO_PRS_HI)
            pn_demo = '0;
        else if (s1_prs_reg <= DEMO_PRS_LO)
            pn_demo = DEMO_PRS_SPAN;
        else
            pn_demo = PSPAN_W'(DEMO_PRS_HI - s1_prs_reg);
    end

    // Weighted score numerators by constant coefficients.
    assign num_nrm  = NUM_W'(fn_nrm) * NRM_FLOW_WT + NUM_W'(pn_nrm) * NRM_PRS_WT;
    assign num_demo = NUM_W'(fn_demo) * DEMO_FLOW_WT + NUM_W'(pn_demo) * DEMO_PRS_WT;

    // Stage-one decisions against the thresholds.
    always_comb
    begin
        s2_next.demo      = demo_mode_reg;
        s2_next.sensor_ok = s1_ok_reg;
        s2_next.no_flow   = demo_mode_reg && (s1_flow_reg <= NOFLOW_C);
        s2_next.f_anom    = s1_flow_reg >= flow_alert_reg;
        s2_next.f_crit    = s1_flow_reg >= flow_crit_reg;
        s2_next.p_low     = s1_prs_reg <= prs_alert_reg;
        s2_next.p_crit    = s1_prs_reg <= prs_crit_reg;
        s2_next.p_recov   = s1_prs_reg >= prs_recov_reg;
        s2_next.f_exit    = s1_flow_reg <= flow_exit_reg;
        s2_next.p_exit    = s1_prs_reg >= prs_exit_reg;
        s2_next.f_latch   = s1_flow_reg > LATCH_FLOW_MIN;
        if (demo_mode_reg)
        begin
            s2_next.num     = num_demo;
            s2_next.risk_hi = num_demo >= DEMO_RISK_HI_NUM;
        end
        else
        begin
            s2_next.num     = num_nrm;
            s2_next.risk_hi = num_nrm >= NRM_RISK_HI_NUM;
        end
    end

    // Score quotient by reciprocal multiplication, exact over the value range.
    assign quot_in = s2_reg.num[NUM_W-1:2];
    assign recip   = s2_reg.demo ? DEMO_RECIP : NRM_RECIP;
    assign prod    = PROD_W'(quot_in) * PROD_W'(recip);
    assign score   = prod[RECIP_SHIFT+RISK_W-1:RECIP_SHIFT];

    assign score_cap_low  = (score > RISK_CAP_LOW)  ? RISK_CAP_LOW  : score;
    assign score_cap_hlth = (score > RISK_CAP_HLTH) ? RISK_CAP_HLTH : score;

    // Saturating and floored counter steps.
    assign alert_inc = (alert_cnt_reg >= CAP_C) ? CAP_C : alert_cnt_reg + 1'b1;
    assign crit_inc  = (crit_cnt_reg >= CAP_C) ? CAP_C : crit_cnt_reg + 1'b1;
    assign alert_dec = (alert_cnt_reg == '0) ? '0 : alert_cnt_reg - 1'b1;
    assign crit_dec  = (crit_cnt_reg == '0) ? '0 : crit_cnt_reg - 1'b1;

    // Classification conditions, using the latch as updated by this reading.
    assign press_eff = press_reg || s2_reg.p_recov || s2_reg.f_latch;
    assign crit      = (s2_reg.f_crit && s2_reg.p_low) || (s2_reg.f_anom && s2_reg.p_crit)
                       || (s2_reg.demo && press_eff && s2_reg.p_crit);
    assign alert     = s2_reg.f_anom || s2_reg.p_low || s2_reg.risk_hi;
    assign healthy   = s2_reg.f_exit && s2_reg.p_exit && !s2_reg.risk_hi;

    // Stage-two status, risk and state update.
    always_comb
    begin
        alert_cnt_next = alert_cnt_reg;
        crit_cnt_next  = crit_cnt_reg;
        press_next     = press_reg;
        status_next    = ST_NORMAL;
        risk_next      = score;
        if (!s2_reg.sensor_ok)
        begin
            alert_cnt_next = '0;
            crit_cnt_next  = '0;
            status_next    = ST_ERROR;
            risk_next      = RISK_ERROR;
        end
        else if (s2_reg.no_flow)
        begin
            alert_cnt_next = '0;
            crit_cnt_next  = '0;
            risk_next      = score_cap_low;
        end
        else
        begin
            press_next = press_eff;
            if (s2_reg.p_recov && s2_reg.f_exit)
            begin
                // Fast recovery to normal.
                alert_cnt_next = '0;
                crit_cnt_next  = '0;
                risk_next      = score_cap_low;
            end
            else if (crit)
            begin
                alert_cnt_next = alert_inc;
                crit_cnt_next  = crit_inc;
                status_next    = (crit_inc >= CRIT_C) ? ST_LEAK : ST_ALERT;
            end
            else if (alert)
            begin
                alert_cnt_next = alert_inc;
                crit_cnt_next  = crit_dec;
                status_next    = (alert_inc >= ALERT_C) ? ST_ALERT : ST_NORMAL;
            end
            else if (healthy)
            begin
                alert_cnt_next = '0;
                crit_cnt_next  = '0;
                risk_next      = score_cap_hlth;
            end
            else
            begin
                alert_cnt_next = alert_dec;
                crit_cnt_next  = crit_dec;
                if (crit_dec >= CRIT_C)
                    status_next = ST_LEAK;
                else if (alert_dec != '0)
                    status_next = ST_ALERT;
                else
                    status_next = ST_NORMAL;
            end
        end
    end

    // Control registers: stage valids and classifier state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            alert_cnt_reg <= '0;
            crit_cnt_reg  <= '0;
            press_reg     <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= in_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (out_en)
                out_valid_reg <= s2_valid_reg;
            if (out_en && s2_valid_reg)
            begin
                alert_cnt_reg <= alert_cnt_next;
                crit_cnt_reg  <= crit_cnt_next;
                press_reg     <= press_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_flow_reg <= flow;
            s1_prs_reg  <= pressure;
            s1_ok_reg   <= sensor_ok;
        end
        if (s2_en && s1_valid_reg)
            s2_reg <= s2_next;
        if (out_en && s2_valid_reg)
        begin
            status_reg <= status_next;
            risk_reg   <= risk_next;
        end
    end

    // The counters never pass their cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        alert_cnt_reg <= CAP_C && crit_cnt_reg <= CAP_C)
    else $error("classifier counter above cap");

    // Once set, the pressurized latch stays set until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        press_reg |=> press_reg)
    else $error("pressurized latch cleared without reset");

    // A sensor error result always carries the fixed error risk.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_ERROR |-> risk_reg == RISK_ERROR)
    else $error("sensor error with wrong risk");

    // Scores stay within the percent range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> risk_reg <= RISK_MAX)
    else $error("risk above 100");

    // A leak result is backed by the critical counter that produced it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_LEAK |-> crit_cnt_reg >= CRIT_C)
    else $error("leak reported with low critical count");

endmodule

// ===== tb/sv/leak_state_classifier_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak state classifier checker
// Watches the configuration, reading and result channels of the leak state
// classifier. It keeps its own copy of the thresholds and of the hysteresis
// state, works out the status and risk for every accepted reading, and
// compares the results in order. It hands back a mismatch count and the
// number of results still outstanding.
// ----------------------------------------------------------------------------
module leak_state_classifier_checker
    import lsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  cfg_index_t        cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [DATA_W-1:0] flow,
    input  logic [DATA_W-1:0] pressure,
    input  logic              sensor_ok,
    input  logic              out_valid,
    input  logic              out_ready,
    input  status_t           status,
    input  logic [RISK_W-1:0] risk,
    output int                mismatches,
    output int                outstanding
);

    // Scoring ranges and weights: risk = floor(55 * Sf + 45 * Sp).
    localparam int NORM_FLOW_BASE = 60;
    localparam int NORM_FLOW_SPAN = 220;
    localparam int NORM_PRS_TOP   = 3000;
    localparam int NORM_PRS_SPAN  = 1300;
    localparam int NORM_FLOW_GAIN = 65;
    localparam int NORM_PRS_GAIN  = 9;
    localparam int NORM_DIVISOR   = 260;
    localparam int DEMO_FLOW_BASE = 900;
    localparam int DEMO_FLOW_SPAN = 500;
    localparam int DEMO_PRS_TOP   = 350;
    localparam int DEMO_PRS_SPAN  = 230;
    localparam int DEMO_FLOW_GAIN = 253;
    localparam int DEMO_PRS_GAIN  = 450;
    localparam int DEMO_DIVISOR   = 2300;

    // Fixed risk values, caps and the hysteresis thresholds.
    localparam int FAULT_RISK      = 5;
    localparam int QUIET_RISK_CAP  = 15;
    localparam int HEALTH_RISK_CAP = 20;
    localparam int HIGH_RISK       = 35;
    localparam int LATCH_FLOW      = 20;

    typedef struct {
        status_t           status;
        logic [RISK_W-1:0] risk;
    } verdict_t;

    // Results predicted but not yet seen on the result channel.
    verdict_t expected_verdicts[$];

    // Shadow copy of the configuration registers.
    logic              demo_on;
    logic [DATA_W-1:0] flow_alert_lvl;
    logic [DATA_W-1:0] flow_crit_lvl;
    logic [DATA_W-1:0] prs_alert_lvl;
    logic [DATA_W-1:0] prs_crit_lvl;
    logic [DATA_W-1:0] prs_recovery_lvl;
    logic [DATA_W-1:0] flow_exit_lvl;
    logic [DATA_W-1:0] prs_exit_lvl;

    // Shadow copy of the hysteresis state.
    int   alert_cnt;
    int   crit_cnt;
    logic line_pressurized;

    function automatic int clip_span(int v, int span);
        if (v < 0)
            return 0;
        if (v > span)
            return span;
        return v;
    endfunction

    function automatic int clip_max(int v, int m);
        return (v > m) ? m : v;
    endfunction

    function automatic int count_up(int c);
        return (c + 1 > COUNT_CAP_DEF) ? COUNT_CAP_DEF : c + 1;
    endfunction

    function automatic int count_down(int c);
        return (c > 0) ? c - 1 : 0;
    endfunction

    // Weighted flow and pressure fractions, floored exactly.
    function automatic int score_reading(int f, int p);
        int fn;
        int pn;
        if (demo_on)
        begin
            fn = clip_span(f - DEMO_FLOW_BASE, DEMO_FLOW_SPAN);
            pn = clip_span(DEMO_PRS_TOP - p, DEMO_PRS_SPAN);
            return (DEMO_FLOW_GAIN * fn + DEMO_PRS_GAIN * pn) / DEMO_DIVISOR;
        end
        fn = clip_span(f - NORM_FLOW_BASE, NORM_FLOW_SPAN);
        pn = clip_span(NORM_PRS_TOP - p, NORM_PRS_SPAN);
        return (NORM_FLOW_GAIN * fn + NORM_PRS_GAIN * pn) / NORM_DIVISOR;
    endfunction

    // Classifies one reading and advances the counters and the latch.
    task automatic classify_reading(input logic [DATA_W-1:0] f, input logic [DATA_W-1:0] p,
                                    input logic ok, output verdict_t v);
        int   fv;
        int   pv;
        int   score;
        logic f_anom;
        logic f_crit;
        logic p_low;
        logic p_crit;
        logic crit;
        logic alert;
        logic healthy;
        fv    = f;
        pv    = p;
        score = score_reading(fv, pv);
        if (!ok)
        begin
            // A sensor fault clears the counters but keeps the latch.
            alert_cnt = 0;
            crit_cnt  = 0;
            v.status  = ST_ERROR;
            v.risk    = RISK_W'(FAULT_RISK);
        end
        else if (demo_on && fv <= NO_FLOW_MAX_DEF)
        begin
            // No flow in demo mode reads as normal.
            alert_cnt = 0;
            crit_cnt  = 0;
            v.status  = ST_NORMAL;
            v.risk    = RISK_W'(clip_max(score, QUIET_RISK_CAP));
        end
        else
        begin
            if (p >= prs_recovery_lvl || fv > LATCH_FLOW)
                line_pressurized = 1'b1;
            if (p >= prs_recovery_lvl && f <= flow_exit_lvl)
            begin
                // Fast recovery to normal.
                alert_cnt = 0;
                crit_cnt  = 0;
                v.status  = ST_NORMAL;
                v.risk    = RISK_W'(clip_max(score, QUIET_RISK_CAP));
            end
            else
            begin
                f_anom  = (f >= flow_alert_lvl);
                f_crit  = (f >= flow_crit_lvl);
                p_low   = (p <= prs_alert_lvl);
                p_crit  = (p <= prs_crit_lvl);
                crit    = (f_crit && p_low) || (f_anom && p_crit) ||
                          (demo_on && line_pressurized && p_crit);
                alert   = f_anom || p_low || (score >= HIGH_RISK);
                healthy = (f <= flow_exit_lvl) && (p >= prs_exit_lvl) && (score < HIGH_RISK);
                v.risk  = RISK_W'(score);
                if (crit)
                begin
                    crit_cnt  = count_up(crit_cnt);
                    alert_cnt = count_up(alert_cnt);
                    v.status  = (crit_cnt >= CRITICAL_READINGS_DEF) ? ST_LEAK : ST_ALERT;
                end
                else if (alert)
                begin
                    alert_cnt = count_up(alert_cnt);
                    crit_cnt  = count_down(crit_cnt);
                    v.status  = (alert_cnt >= ALERT_READINGS_DEF) ? ST_ALERT : ST_NORMAL;
                end
                else if (healthy)
                begin
                    alert_cnt = 0;
                    crit_cnt  = 0;
                    v.status  = ST_NORMAL;
                    v.risk    = RISK_W'(clip_max(score, HEALTH_RISK_CAP));
                end
                else
                begin
                    alert_cnt = count_down(alert_cnt);
                    crit_cnt  = count_down(crit_cnt);
                    if (crit_cnt >= CRITICAL_READINGS_DEF)
                        v.status = ST_LEAK;
                    else if (alert_cnt >= 1)
                        v.status = ST_ALERT;
                    else
                        v.status = ST_NORMAL;
                end
            end
        end
    endtask

    // Channel monitor: register writes, predictions and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        verdict_t predicted;
        verdict_t wanted;
        if (!rst_n)
        begin
            demo_on          = 1'b0;
            flow_alert_lvl   = FLOW_ALERT_RST;
            flow_crit_lvl    = FLOW_CRITICAL_RST;
            prs_alert_lvl    = PRS_ALERT_RST;
            prs_crit_lvl     = PRS_CRITICAL_RST;
            prs_recovery_lvl = PRS_RECOVERY_RST;
            flow_exit_lvl    = FLOW_EXIT_RST;
            prs_exit_lvl     = PRS_EXIT_RST;
            alert_cnt        = 0;
            crit_cnt         = 0;
            line_pressurized = 1'b0;
            mismatches       = 0;
            expected_verdicts.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DEMO_MODE:     demo_on          = cfg_data[0];
                    REG_FLOW_ALERT:    flow_alert_lvl   = cfg_data;
                    REG_FLOW_CRITICAL: flow_crit_lvl    = cfg_data;
                    REG_PRS_ALERT:     prs_alert_lvl    = cfg_data;
                    REG_PRS_CRITICAL:  prs_crit_lvl     = cfg_data;
                    REG_PRS_RECOVERY:  prs_recovery_lvl = cfg_data;
                    REG_FLOW_EXIT:     flow_exit_lvl    = cfg_data;
                    REG_PRS_EXIT:      prs_exit_lvl     = cfg_data;
                    default:           ;
                endcase
            end

            if (in_valid && in_ready)
            begin
                classify_reading(flow, pressure, sensor_ok, predicted);
                expected_verdicts.push_back(predicted);
            end

            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d, risk %0d",
                           status, risk);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_verdicts.pop_front();
                    if (status !== wanted.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               wanted.status, status);
                        mismatches++;
                    end
                    if (risk !== wanted.risk)
                    begin
                        $error("risk mismatch: expected %0d, actual %0d", wanted.risk, risk);
                        mismatches++;
                    end
                end
            end

            outstanding <= expected_verdicts.size();
        end
    end

endmodule

// ===== tb/sv/leak_state_classifier_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leak state classifier unit testbench
// Drives readings and register writes into the classifier with random gaps
// and result stalls. A directed pass covers the field extremes, sensor
// faults, the demo no-flow shortcut, the pressurized latch, fast recovery
// and every status branch; random runs of similar readings then build up
// and decay the counters under several threshold settings. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module leak_state_classifier_unit_tb;
    import lsc_pkg::*;

    localparam int PHASES             = 9;
    localparam int READINGS_PER_PHASE = 178;
    localparam int QUIET_LIMIT        = 1000;
    localparam int SETTLE_CYCLES      = 8;

    // Threshold settings used across the phases.
    localparam int SET_DEFAULT   = 0;
    localparam int SET_DEMO      = 1;
    localparam int SET_ZERO      = 2;
    localparam int SET_FULL      = 3;
    localparam int SET_DEMO_ZERO = 4;
    localparam int SET_DEMO_FULL = 5;
    localparam int SET_RANDOM    = 6;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = REG_DEMO_MODE;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [DATA_W-1:0] flow      = '0;
    logic [DATA_W-1:0] pressure  = '0;
    logic              sensor_ok = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    status_t           status;
    logic [RISK_W-1:0] risk;

    int mismatches;
    int outstanding;
    int gap_pct   = 6;
    int stall_pct = 45;
    int quiet_cycles = 0;

    // Stimulus-side copy of the thresholds, used to aim readings at them.
    logic              demo_sel;
    logic [DATA_W-1:0] level [REG_FLOW_ALERT:REG_PRS_EXIT];

    leak_state_classifier_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .flow      (flow),
        .pressure  (pressure),
        .sensor_ok (sensor_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .risk      (risk)
    );

    leak_state_classifier_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .flow        (flow),
        .pressure    (pressure),
        .sensor_ok   (sensor_ok),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .risk        (risk),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result receiver with random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on cycles in which no transaction completes.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // A value a few counts around a level, kept inside the field range.
    function automatic logic [DATA_W-1:0] near_level(int base, int spread);
        int v;
        v = base + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return DATA_W'(v);
    endfunction

    function automatic logic [DATA_W-1:0] pick_flow();
        case ($urandom_range(6))
            0: return DATA_W'($urandom_range(30));
            1: return demo_sel ? DATA_W'($urandom_range(1450, 850))
                               : DATA_W'($urandom_range(320, 40));
            2:
            begin
                case ($urandom_range(2))
                    0:       return near_level(level[REG_FLOW_ALERT], 2);
                    1:       return near_level(level[REG_FLOW_CRITICAL], 2);
                    default: return near_level(level[REG_FLOW_EXIT], 2);
                endcase
            end
            3:
            begin
                case ($urandom_range(3))
                    0:       return near_level(LATCH_FLOW_MIN, 2);
                    1:       return near_level(NO_FLOW_MAX_DEF, 2);
                    2:       return near_level(demo_sel ? DEMO_FLOW_LO : NRM_FLOW_LO, 2);
                    default: return near_level(demo_sel ? DEMO_FLOW_HI : NRM_FLOW_HI, 2);
                endcase
            end
            4: return DATA_W'($urandom);
            5: return $urandom_range(1) ? DATA_W'(65535 - $urandom_range(3))
                                        : DATA_W'($urandom_range(3));
            default: return DATA_W'($urandom_range(2000));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_pressure();
        case ($urandom_range(5))
            0: return demo_sel ? DATA_W'($urandom_range(400)) : DATA_W'($urandom_range(3200));
            1:
            begin
                case ($urandom_range(3))
                    0:       return near_level(level[REG_PRS_ALERT], 2);
                    1:       return near_level(level[REG_PRS_CRITICAL], 2);
                    2:       return near_level(level[REG_PRS_RECOVERY], 2);
                    default: return near_level(level[REG_PRS_EXIT], 2);
                endcase
            end
            2: return $urandom_range(1) ? near_level(demo_sel ? DEMO_PRS_LO : NRM_PRS_LO, 2)
                                        : near_level(demo_sel ? DEMO_PRS_HI : NRM_PRS_HI, 2);
            3: return DATA_W'($urandom);
            4: return $urandom_range(1) ? DATA_W'(65535 - $urandom_range(3))
                                        : DATA_W'($urandom_range(3));
            default: return DATA_W'($urandom_range(3500));
        endcase
    endfunction

    // Sends one reading transaction, with a random gap ahead of it.
    task automatic send_reading(input logic [DATA_W-1:0] f, input logic [DATA_W-1:0] p,
                                input logic ok);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        flow      <= f;
        pressure  <= p;
        sensor_ok <= ok;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Writes one register; the caller lowers the valid after its last write.
    task automatic write_register(input cfg_index_t idx, input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stops readings and waits until every predicted result has arrived.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Chooses a threshold setting and writes every register with it.
    task automatic load_setting(input int kind);
        logic [DATA_W-1:0] fill;
        case (kind)
            SET_DEFAULT:
            begin
                demo_sel                  = 1'b0;
                level[REG_FLOW_ALERT]     = FLOW_ALERT_RST;
                level[REG_FLOW_CRITICAL]  = FLOW_CRITICAL_RST;
                level[REG_PRS_ALERT]      = PRS_ALERT_RST;
                level[REG_PRS_CRITICAL]   = PRS_CRITICAL_RST;
                level[REG_PRS_RECOVERY]   = PRS_RECOVERY_RST;
                level[REG_FLOW_EXIT]      = FLOW_EXIT_RST;
                level[REG_PRS_EXIT]       = PRS_EXIT_RST;
            end
            SET_DEMO:
            begin
                demo_sel                  = 1'b1;
                level[REG_FLOW_ALERT]     = 16'd1000;
                level[REG_FLOW_CRITICAL]  = 16'd1300;
                level[REG_PRS_ALERT]      = 16'd250;
                level[REG_PRS_CRITICAL]   = 16'd150;
                level[REG_PRS_RECOVERY]   = 16'd330;
                level[REG_FLOW_EXIT]      = 16'd700;
                level[REG_PRS_EXIT]       = 16'd300;
            end
            SET_RANDOM:
            begin
                demo_sel = 1'($urandom_range(1));
                for (int i = REG_FLOW_ALERT; i <= REG_PRS_EXIT; i++)
                    level[i] = $urandom_range(3) ? DATA_W'($urandom_range(3500))
                                                 : DATA_W'($urandom);
            end
            default:
            begin
                // Extremes: every threshold at zero or at full scale.
                demo_sel = (kind == SET_DEMO_ZERO) || (kind == SET_DEMO_FULL);
                fill     = ((kind == SET_FULL) || (kind == SET_DEMO_FULL)) ? '1 : '0;
                for (int i = REG_FLOW_ALERT; i <= REG_PRS_EXIT; i++)
                    level[i] = fill;
            end
        endcase
        write_register(REG_DEMO_MODE, {15'($urandom), demo_sel});
        write_register(REG_FLOW_ALERT, level[REG_FLOW_ALERT]);
        write_register(REG_FLOW_CRITICAL, level[REG_FLOW_CRITICAL]);
        write_register(REG_PRS_ALERT, level[REG_PRS_ALERT]);
        write_register(REG_PRS_CRITICAL, level[REG_PRS_CRITICAL]);
        write_register(REG_PRS_RECOVERY, level[REG_PRS_RECOVERY]);
        write_register(REG_FLOW_EXIT, level[REG_FLOW_EXIT]);
        write_register(REG_PRS_EXIT, level[REG_PRS_EXIT]);
        // A write to an index past the last register must change nothing.
        write_register(cfg_index_t'(REG_PRS_EXIT + 1 + $urandom_range(7)), DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Mostly runs of similar readings, so the counters climb, saturate and
    // decay; the rest is unrelated noise.
    task automatic random_readings(input int count);
        int                sent;
        int                run_len;
        logic [DATA_W-1:0] base_f;
        logic [DATA_W-1:0] base_p;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) < 2)
            begin
                send_reading(DATA_W'($urandom), DATA_W'($urandom), 1'($urandom_range(1)));
                sent++;
            end
            else
            begin
                run_len = $urandom_range(14, 1);
                base_f  = pick_flow();
                base_p  = pick_pressure();
                for (int i = 0; i < run_len && sent < count; i++)
                begin
                    send_reading(near_level(base_f, 3), near_level(base_p, 3),
                                 $urandom_range(11) != 0);
                    sent++;
                end
            end
        end
    endtask

    function automatic int phase_setting(input int k);
        case (k)
            0:       return SET_DEFAULT;
            1:       return SET_DEMO;
            2:       return SET_ZERO;
            3:       return SET_DEFAULT;
            4:       return SET_DEMO_FULL;
            5:       return SET_RANDOM;
            6:       return SET_FULL;
            7:       return SET_DEMO;
            default: return SET_DEMO_ZERO;
        endcase
    endfunction

    // Main stimulus sequence and verdict.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Demo mode first, while the pressurized latch is still clear.
        load_setting(SET_DEMO);
        send_reading(16'd3, 16'd100, 1'b1);
        send_reading(16'd5, 16'd0, 1'b1);
        send_reading(16'd0, 16'hFFFF, 1'b0);
        send_reading(16'd6, 16'd100, 1'b1);
        send_reading(16'd20, 16'd150, 1'b1);
        send_reading(16'd21, 16'd100, 1'b1);
        send_reading(16'd10, 16'd100, 1'b1);
        send_reading(16'd1400, 16'd0, 1'b1);
        send_reading(16'hFFFF, 16'hFFFF, 1'b1);
        send_reading(16'd600, 16'd340, 1'b1);
        drain_results();

        // Normal mode at the reset thresholds: every status branch.
        load_setting(SET_DEFAULT);
        send_reading(16'd0, 16'd0, 1'b1);
        send_reading(16'hFFFF, 16'hFFFF, 1'b1);
        send_reading(16'd0, 16'hFFFF, 1'b0);
        send_reading(16'd50, 16'd3000, 1'b1);
        send_reading(16'd70, 16'd2700, 1'b1);
        send_reading(16'd100, 16'd2500, 1'b1);
        repeat (3) send_reading(16'd220, 16'd2500, 1'b1);
        repeat (4) send_reading(16'd300, 16'd2000, 1'b1);
        send_reading(16'd100, 16'd2500, 1'b1);
        send_reading(16'hFFFF, 16'd0, 1'b1);

        // Random phases under changing settings and idling patterns.
        for (int k = 0; k < PHASES; k++)
        begin
            if (k == 3)
            begin
                gap_pct   = 45;
                stall_pct = 6;
            end
            else if (k == 6)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            drain_results();
            load_setting(phase_setting(k));
            random_readings(READINGS_PER_PHASE);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lsc_pkg.sv
hdl/leak_state_classifier_unit.sv
tb/sv/leak_state_classifier_checker.sv
tb/sv/leak_state_classifier_unit_tb.sv
